// ----- rtl/dtw_pkg.sv -----
// Package for the date to day number and ISO week unit.
// Holds the calendar constants, the stage payload types and the month tables.
// Used by every module in rtl; depends on nothing.
package dtw_pkg;

    localparam int unsigned MAX_YEAR = 9999;
    localparam int unsigned EPOCH_YEAR = 1601;
    localparam int unsigned DAYS_PER_YEAR = 365;
    localparam int unsigned LEAPS_BEFORE_EPOCH = 388;
    localparam int unsigned CENT_RECIP = 5243;
    localparam int unsigned CENT_SHIFT = 19;
    localparam int unsigned WEEK_RECIP = 293;
    localparam int unsigned WEEK_SHIFT = 11;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [2:0] WD_WEDNESDAY = 3'd3;
    localparam logic [2:0] WD_THURSDAY = 3'd4;

    localparam logic [5:0] WEEKS_SHORT = 6'd52;
    localparam logic [5:0] WEEKS_LONG = 6'd53;
    localparam logic [5:0] WEEK_FIRST = 6'd1;

    typedef struct packed {
        logic        vld;
        logic        ok;
        logic [22:0] jan1;
        logic [8:0]  ordinal;
        logic        leap;
        logic        leap_prev;
        logic        first_year;
    } yr_item_t;

    typedef struct packed {
        logic        vld;
        logic        ok;
        logic [22:0] dn;
        logic [2:0]  wd;
        logic        before_w1;
        logic [8:0]  week_num;
        logic        long_yr;
        logic        prev_long;
    } dy_item_t;

    typedef struct packed {
        logic        vld;
        logic        valid_res;
        logic [21:0] day_number;
        logic [2:0]  weekday;
        logic [5:0]  iso_week;
        logic        long_year;
    } res_t;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2: len = 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] db;
        case (m)
            4'd1: db = 9'd0;
            4'd2: db = 9'd31;
            4'd3: db = 9'd59;
            4'd4: db = 9'd90;
            4'd5: db = 9'd120;
            4'd6: db = 9'd151;
            4'd7: db = 9'd181;
            4'd8: db = 9'd212;
            4'd9: db = 9'd243;
            4'd10: db = 9'd273;
            4'd11: db = 9'd304;
            4'd12: db = 9'd334;
            default: db = 9'd0;
        endcase
        return db;
    endfunction

    // 8 == 1 mod 7: fold octal digits
    function automatic logic [2:0] mod7(input logic [22:0] x);
        logic [23:0] xw;
        logic [5:0]  s;
        logic [3:0]  f1;
        logic [3:0]  f2;
        logic [2:0]  r;
        xw = {1'b0, x};
        s = 6'd0;
        for (int i = 0; i < 8; i++) begin
            s = s + 6'(xw[3*i +: 3]);
        end
        f1 = 4'(s[5:3]) + 4'(s[2:0]);
        f2 = 4'(f1[3]) + 4'(f1[2:0]);
        r = (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
        return r;
    endfunction

endpackage

// ----- rtl/dtw_year.sv -----
// Year stages of the date unit: range checks, century split, leap flags,
// January 1 day number and ordinal day. Depends on dtw_pkg.
module dtw_year (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        en,
    input  logic              in_vld,
    input  logic [13:0]       year,
    input  logic [3:0]        month,
    input  logic [4:0]        day,
    output logic              s1_vld,
    output dtw_pkg::yr_item_t item
);

    logic        s1_vld_reg;
    logic        s1_ok_reg;
    logic [13:0] s1_year_reg;
    logic [3:0]  s1_month_reg;
    logic [4:0]  s1_day_reg;
    logic [13:0] s1_k_reg;
    logic [7:0]  s1_cent_reg;

    logic        ok_next;
    logic [13:0] k_next;
    logic [26:0] cent_prod;
    logic [7:0]  cent_next;

    dtw_pkg::yr_item_t item_reg;
    dtw_pkg::yr_item_t item_next;

    logic [6:0]  rk;
    logic [6:0]  ry;
    logic [7:0]  cy;
    logic        leap;
    logic        leap_prev;
    logic [13:0] n_yrs;
    logic [4:0]  mlen;

    function automatic logic [13:0] s_dec(input logic [13:0] y);
        return y - 14'd1;
    endfunction

    assign k_next = s_dec(year);
    assign cent_prod = 27'(k_next) * 27'(dtw_pkg::CENT_RECIP);
    assign cent_next = 8'(cent_prod >> dtw_pkg::CENT_SHIFT);
    assign ok_next = (year >= 14'(dtw_pkg::EPOCH_YEAR))
                     && (17'(year) <= 17'(dtw_pkg::MAX_YEAR))
                     && (month >= dtw_pkg::MONTH_JAN) && (month <= dtw_pkg::MONTH_DEC)
                     && (day != 5'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en[0]) begin
            s1_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s1_ok_reg <= ok_next;
            s1_year_reg <= year;
            s1_month_reg <= month;
            s1_day_reg <= day;
            s1_k_reg <= k_next;
            s1_cent_reg <= cent_next;
        end
    end

    always_comb begin
        rk = 7'(s1_k_reg - 14'(s1_cent_reg) * 14'd100);
        leap_prev = (s1_k_reg[1:0] == 2'd0) && ((rk != 7'd0) || (s1_cent_reg[1:0] == 2'd0));
        if (rk == 7'd99) begin
            ry = 7'd0;
            cy = s1_cent_reg + 8'd1;
        end else begin
            ry = rk + 7'd1;
            cy = s1_cent_reg;
        end
        leap = (s1_year_reg[1:0] == 2'd0) && ((ry != 7'd0) || (cy[1:0] == 2'd0));
        n_yrs = s1_year_reg - 14'(dtw_pkg::EPOCH_YEAR);
        mlen = dtw_pkg::month_len(s1_month_reg)
               + 5'((s1_month_reg == dtw_pkg::MONTH_FEB) && leap);

        item_next.vld = s1_vld_reg;
        item_next.ok = s1_ok_reg && (s1_day_reg <= mlen);
        item_next.jan1 = 23'(n_yrs) * 23'(dtw_pkg::DAYS_PER_YEAR)
                         + 23'(s1_k_reg[13:2]) - 23'(s1_cent_reg)
                         + 23'(s1_cent_reg[7:2]) - 23'(dtw_pkg::LEAPS_BEFORE_EPOCH);
        item_next.ordinal = dtw_pkg::days_before(s1_month_reg)
                            + 9'((s1_month_reg > dtw_pkg::MONTH_FEB) && leap)
                            + 9'(s1_day_reg);
        item_next.leap = leap;
        item_next.leap_prev = leap_prev;
        item_next.first_year = (s1_year_reg == 14'(dtw_pkg::EPOCH_YEAR));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.vld <= 1'b0;
        end else if (en[1]) begin
            item_reg.vld <= item_next.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            item_reg.ok <= item_next.ok;
            item_reg.jan1 <= item_next.jan1;
            item_reg.ordinal <= item_next.ordinal;
            item_reg.leap <= item_next.leap;
            item_reg.leap_prev <= item_next.leap_prev;
            item_reg.first_year <= item_next.first_year;
        end
    end

    assign s1_vld = s1_vld_reg;
    assign item = item_reg;

endmodule

// ----- rtl/dtw_day.sv -----
// Day stages of the date unit: day number, weekdays of January 1 in this and
// the previous year, long-year flags and the week estimate. Depends on dtw_pkg.
module dtw_day (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        en,
    input  dtw_pkg::yr_item_t yr,
    output logic              s3_vld,
    output dtw_pkg::dy_item_t item
);

    logic        s3_vld_reg;
    logic        s3_ok_reg;
    logic [22:0] s3_dn_reg;
    logic [2:0]  s3_j7_reg;
    logic [8:0]  s3_ordinal_reg;
    logic        s3_leap_reg;
    logic        s3_leap_prev_reg;
    logic        s3_first_reg;

    logic [22:0] dn_next;
    logic [2:0]  j7_next;

    dtw_pkg::dy_item_t item_reg;
    dtw_pkg::dy_item_t item_next;

    logic [2:0]  wd;
    logic [2:0]  wd1;
    logic [3:0]  pj_sum;
    logic [2:0]  pj;
    logic [2:0]  wdp;
    logic [9:0]  ord_sum;

    assign dn_next = yr.jan1 + 23'(yr.ordinal) - 23'd1;
    assign j7_next = dtw_pkg::mod7(yr.jan1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (en[0]) begin
            s3_vld_reg <= yr.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s3_ok_reg <= yr.ok;
            s3_dn_reg <= dn_next;
            s3_j7_reg <= j7_next;
            s3_ordinal_reg <= yr.ordinal;
            s3_leap_reg <= yr.leap;
            s3_leap_prev_reg <= yr.leap_prev;
            s3_first_reg <= yr.first_year;
        end
    end

    always_comb begin
        wd = dtw_pkg::mod7(s3_dn_reg) + 3'd1;
        wd1 = s3_j7_reg + 3'd1;
        pj_sum = 4'(s3_j7_reg) + 4'd6 - 4'(s3_leap_prev_reg);
        pj = (pj_sum >= 4'd7) ? 3'(pj_sum - 4'd7) : pj_sum[2:0];
        wdp = pj + 3'd1;
        ord_sum = 10'(s3_ordinal_reg) + 10'd10;

        item_next.vld = s3_vld_reg;
        item_next.ok = s3_ok_reg;
        item_next.dn = s3_dn_reg;
        item_next.wd = wd;
        item_next.before_w1 = ord_sum < (10'(wd) + 10'd7);
        item_next.week_num = 9'(ord_sum - 10'(wd));
        item_next.long_yr = (wd1 == dtw_pkg::WD_THURSDAY)
                            || (s3_leap_reg && (wd1 == dtw_pkg::WD_WEDNESDAY));
        item_next.prev_long = !s3_first_reg
                              && ((wdp == dtw_pkg::WD_THURSDAY)
                                  || (s3_leap_prev_reg && (wdp == dtw_pkg::WD_WEDNESDAY)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.vld <= 1'b0;
        end else if (en[1]) begin
            item_reg.vld <= item_next.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            item_reg.ok <= item_next.ok;
            item_reg.dn <= item_next.dn;
            item_reg.wd <= item_next.wd;
            item_reg.before_w1 <= item_next.before_w1;
            item_reg.week_num <= item_next.week_num;
            item_reg.long_yr <= item_next.long_yr;
            item_reg.prev_long <= item_next.prev_long;
        end
    end

    assign s3_vld = s3_vld_reg;
    assign item = item_reg;

endmodule

// ----- rtl/dtw_week.sv -----
// Output stage of the date unit: week number by reciprocal divide, year-edge
// correction and zeroing of invalid dates. Depends on dtw_pkg.
module dtw_week (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  dtw_pkg::dy_item_t dy,
    output dtw_pkg::res_t     res
);

    dtw_pkg::res_t res_reg;
    dtw_pkg::res_t res_next;

    logic [19:0] q_prod;
    logic [5:0]  q;
    logic [5:0]  nweeks;
    logic [5:0]  week;

    always_comb begin
        q_prod = 20'(dy.week_num) * 20'(dtw_pkg::WEEK_RECIP);
        q = 6'(q_prod >> dtw_pkg::WEEK_SHIFT);
        nweeks = dy.long_yr ? dtw_pkg::WEEKS_LONG : dtw_pkg::WEEKS_SHORT;
        if (dy.before_w1) begin
            week = dy.prev_long ? dtw_pkg::WEEKS_LONG : dtw_pkg::WEEKS_SHORT;
        end else if (q > nweeks) begin
            week = dtw_pkg::WEEK_FIRST;
        end else begin
            week = q;
        end

        res_next.vld = dy.vld;
        res_next.valid_res = dy.ok;
        res_next.day_number = dy.ok ? dy.dn[21:0] : 22'd0;
        res_next.weekday = dy.ok ? dy.wd : 3'd0;
        res_next.iso_week = dy.ok ? week : 6'd0;
        res_next.long_year = dy.ok && dy.long_yr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg.vld <= 1'b0;
        end else if (en) begin
            res_reg.vld <= res_next.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg.valid_res <= res_next.valid_res;
            res_reg.day_number <= res_next.day_number;
            res_reg.weekday <= res_next.weekday;
            res_reg.iso_week <= res_next.iso_week;
            res_reg.long_year <= res_next.long_year;
        end
    end

    assign res = res_reg;

endmodule

// ----- rtl/date_to_day_number_and_iso_week_unit.sv -----
// Date to day number and ISO week unit, top level.
// Throughput: one request per cycle while m_tready does not stall the output.
// Five register stages, each advancing when empty or when the next one advances.
// Reset (aresetn low, synchronous) clears all stage valid bits; payload is not reset.
// Depends on dtw_pkg, dtw_year, dtw_day and dtw_week.
module date_to_day_number_and_iso_week_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // year[13:0], month[17:14], day[22:18], zero[23]
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // valid_res[0], day_number[22:1], weekday[25:23], iso_week[31:26],
    // long_year[32], zero[39:33]
    output logic [39:0] m_tdata
);

    logic [5:1] en;
    logic       s1_vld;
    logic       s3_vld;

    dtw_pkg::yr_item_t yr;
    dtw_pkg::dy_item_t dy;
    dtw_pkg::res_t     res;

    assign en[5] = !res.vld || m_tready;
    assign en[4] = !dy.vld || en[5];
    assign en[3] = !s3_vld || en[4];
    assign en[2] = !yr.vld || en[3];
    assign en[1] = !s1_vld || en[2];

    dtw_year u_year (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en[2:1]),
        .in_vld  (s_tvalid),
        .year    (s_tdata[13:0]),
        .month   (s_tdata[17:14]),
        .day     (s_tdata[22:18]),
        .s1_vld  (s1_vld),
        .item    (yr)
    );

    dtw_day u_day (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en[4:3]),
        .yr      (yr),
        .s3_vld  (s3_vld),
        .item    (dy)
    );

    dtw_week u_week (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en[5]),
        .dy      (dy),
        .res     (res)
    );

    assign s_tready = en[1];
    assign m_tvalid = res.vld;
    assign m_tdata = {7'd0, res.long_year, res.iso_week, res.weekday,
                      res.day_number, res.valid_res};

    a_full_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while pipeline has room");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[39:1] == 39'd0))
        else $error("invalid date result carries nonzero fields");

    a_valid_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> ((m_tdata[25:23] != 3'd0)
                                      && (m_tdata[31:26] != 6'd0)
                                      && (m_tdata[31:26] <= 6'd53)))
        else $error("valid date result has weekday or week out of range");

endmodule
